@@ rtl/core/interval_table_match_and_union_defines.svh @@
// Assertion macros for the interval table checker
`ifndef INTERVAL_TABLE_MATCH_AND_UNION_DEFINES_SVH
`define INTERVAL_TABLE_MATCH_AND_UNION_DEFINES_SVH

// property holds at every clock edge outside reset
`define ITMU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ITMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/itmu_pkg.sv @@
// ----------------------------------------------------------------------------
// itmu_pkg
// Types and codes shared by the interval table block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itmu_pkg;

  localparam int unsigned FieldBits = 64;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAdd    = 2'd1,
    CmdTest   = 2'd2,
    CmdReport = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusFull = 2'd1,
    StatusSat  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                 command;
    logic [FieldBits-1:0] low_bound;
    logic [FieldBits-1:0] high_bound;
    logic [FieldBits-1:0] probe_value;
  } in_beat_t;

  typedef struct packed {
    logic                 probe_hit;
    logic [31:0]          hits_so_far;
    logic [FieldBits-1:0] union_size;
    logic [8:0]           stored_intervals;
    status_e              status;
  } out_beat_t;

endpackage

@@ rtl/core/itmu_ram.sv @@
// ----------------------------------------------------------------------------
// itmu_ram
// Simple dual-port interval memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itmu_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/interval_table_match_and_union.sv @@
// Test scans the table, one entry read per cycle. Report sorts the table in memory
// by insertion sort on the lower bound, then walks the sorted table to merge
// touching spans and sum their sizes, one memory read per cycle.
// One command at a time; the next beat is taken while a result waits at the output.
// Reset: table empty, hit tally zero, no result pending; memory is not cleared.
// ----------------------------------------------------------------------------
// interval_table_match_and_union
// Interval table with membership test, running hit tally and union size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_table_match_and_union
  import itmu_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 256,
  parameter int unsigned VALUE_BITS    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  typedef enum logic [2:0] {
    SIdle, SProbe, SSortKey, SSortLoad, SSortCmp, SSortIns, SMerge, SFin
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [31:0]     tally_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   i_q;
  logic [AW-1:0]   j_q;
  logic            rvld_q;
  logic            first_q;
  logic            hit_q;
  logic [VB-1:0]   probe_q;
  logic [VB-1:0]   key_lo_q;
  logic [VB-1:0]   key_hi_q;
  logic [VB-1:0]   cur_lo_q;
  logic [VB-1:0]   cur_hi_q;
  logic [63:0]     total_q;
  logic            sat_q;
  status_e         status_q;
  logic            out_valid_q;
  out_beat_t       out_data_q;

  // memory port signals
  logic            we;
  logic [AW-1:0]   waddr;
  logic [2*VB-1:0] wdata;
  logic [AW-1:0]   raddr;
  logic [2*VB-1:0] rdata;
  logic [VB-1:0]   rd_lo;
  logic [VB-1:0]   rd_hi;

  logic [VB-1:0]   in_lo;
  logic [VB-1:0]   in_hi;
  logic            accept;
  logic            out_free;
  logic            scan_more;
  logic            swap;
  logic            touch;
  logic [VB-1:0]   span;
  logic [64:0]     sum;
  logic [CW+8:0]   count_ext;

  itmu_ram #(
    .Width(2 * VB),
    .Depth(MAX_INTERVALS),
    .AddrW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_lo     = in_data_i.low_bound[VB-1:0];
  assign in_hi     = in_data_i.high_bound[VB-1:0];
  assign rd_lo     = rdata[VB-1:0];
  assign rd_hi     = rdata[2*VB-1:VB];
  assign in_ready_o = (state_q == SIdle);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_more = (idx_q < count_q);
  assign swap      = (rd_lo > key_lo_q);
  // overlap or adjacency, computed one bit wider so it cannot wrap
  assign touch     = (rd_lo <= cur_hi_q) ||
                     ({1'b0, rd_lo} == ({1'b0, cur_hi_q} + (VB+1)'(1)));
  assign span      = cur_hi_q - cur_lo_q;
  assign sum       = {1'b0, total_q} + 65'(span) + 65'd1;
  assign count_ext = (CW+9)'(count_q);

  // memory address and write control
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = {key_hi_q, key_lo_q};
    raddr = idx_q[AW-1:0];
    case (state_q)
      SIdle: begin
        waddr = count_q[AW-1:0];
        wdata = {in_hi, in_lo};
        we    = accept && (in_data_i.command == CmdAdd) && (in_lo <= in_hi) &&
                (count_q < CW'(MAX_INTERVALS));
      end
      SSortKey:  raddr = i_q[AW-1:0];
      SSortLoad: raddr = i_q[AW-1:0] - AW'(1);
      SSortCmp: begin
        raddr = j_q - AW'(2);
        if (swap) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      SSortIns: we = 1'b1;
      default: ;
    endcase
  end

  // command sequencer, tally, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
      rvld_q      <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            hit_q    <= 1'b0;
            status_q <= StatusOk;
            total_q  <= '0;
            sat_q    <= 1'b0;
            idx_q    <= '0;
            rvld_q   <= 1'b0;
            first_q  <= 1'b1;
            i_q      <= CW'(1);
            probe_q  <= in_data_i.probe_value[VB-1:0];
            state_q  <= SFin;
            case (in_data_i.command)
              CmdClear: begin
                count_q <= '0;
                tally_q <= '0;
              end
              CmdAdd: begin
                if (in_lo <= in_hi) begin
                  if (count_q < CW'(MAX_INTERVALS)) begin
                    count_q <= count_q + CW'(1);
                  end else begin
                    status_q <= StatusFull;
                  end
                end
              end
              CmdTest: state_q <= SProbe;
              CmdReport: begin
                state_q <= (count_q < CW'(2)) ? SMerge : SSortKey;
              end
              default: ;
            endcase
          end
        end
        // scan all entries, one read per cycle
        SProbe: begin
          if (rvld_q && probe_q >= rd_lo && probe_q <= rd_hi) begin
            hit_q <= 1'b1;
          end
          rvld_q <= scan_more;
          if (scan_more) begin
            idx_q <= idx_q + CW'(1);
          end else if (!rvld_q) begin
            if (hit_q && tally_q != 32'hFFFF_FFFF) begin
              tally_q <= tally_q + 32'd1;
            end
            state_q <= SFin;
          end
        end
        // insertion sort by lower bound
        SSortKey: state_q <= SSortLoad;
        SSortLoad: begin
          key_lo_q <= rd_lo;
          key_hi_q <= rd_hi;
          j_q      <= i_q[AW-1:0];
          state_q  <= SSortCmp;
        end
        SSortCmp: begin
          if (swap) begin
            j_q <= j_q - AW'(1);
            if (j_q == AW'(1)) begin
              state_q <= SSortIns;
            end
          end else begin
            state_q <= SSortIns;
          end
        end
        SSortIns: begin
          i_q     <= i_q + CW'(1);
          state_q <= ((i_q + CW'(1)) < count_q) ? SSortKey : SMerge;
        end
        // merge walk over the sorted table
        SMerge: begin
          if (rvld_q) begin
            first_q <= 1'b0;
            if (first_q) begin
              cur_lo_q <= rd_lo;
              cur_hi_q <= rd_hi;
            end else if (touch) begin
              if (rd_hi > cur_hi_q) begin
                cur_hi_q <= rd_hi;
              end
            end else begin
              total_q  <= sum[64] ? '1 : sum[63:0];
              sat_q    <= sat_q | sum[64];
              cur_lo_q <= rd_lo;
              cur_hi_q <= rd_hi;
            end
          end
          rvld_q <= scan_more;
          if (scan_more) begin
            idx_q <= idx_q + CW'(1);
          end else if (!rvld_q) begin
            if (!first_q) begin
              total_q <= sum[64] ? '1 : sum[63:0];
              sat_q   <= sat_q | sum[64];
            end
            state_q <= SFin;
          end
        end
        SFin: begin
          if (out_free) begin
            out_valid_q                 <= 1'b1;
            out_data_q.probe_hit        <= hit_q;
            out_data_q.hits_so_far      <= tally_q;
            out_data_q.union_size       <= total_q;
            out_data_q.stored_intervals <= count_ext[8:0];
            out_data_q.status           <= sat_q ? StatusSat : status_q;
            state_q                     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/itmu_checker.sv @@
// ----------------------------------------------------------------------------
// itmu_checker
// Port-level checks on the interval table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interval_table_match_and_union_defines.svh"

module itmu_checker
  import itmu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  // stalled result beat holds
  `ITMU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // one command at a time
  `ITMU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a hit comes only from a test, which reports no union
  `ITMU_ASSERT(a_hit_no_union, clk_i, rst_ni, !(out_valid_o && out_data_o.probe_hit) || (out_data_o.union_size == '0 && out_data_o.status == StatusOk))
  // saturation shows the full count
  `ITMU_ASSERT(a_sat_full, clk_i, rst_ni, !(out_valid_o && out_data_o.status == StatusSat) || (&out_data_o.union_size))

endmodule

bind interval_table_match_and_union itmu_checker u_itmu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ tb/sv/interval_table_match_and_union_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_match_and_union_checker
// Watches both channels of the interval table, keeps a shadow table, predicts
// one result beat per accepted command and compares each result field by field.
// ----------------------------------------------------------------------------

module interval_table_match_and_union_checker
  import itmu_pkg::*;
#(
  parameter int unsigned MaxEntries = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // shadow of the block state
  logic [63:0] shadow_lo [MaxEntries];
  logic [63:0] shadow_hi [MaxEntries];
  int unsigned shadow_count;
  logic [31:0] shadow_tally;
  out_beat_t   expected_results [$];

  // saturating add on the union total
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          inout logic sat);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[64]) begin
      sat = 1'b1;
      return '1;
    end
    return sum[63:0];
  endfunction

  // sort a copy of the table, merge overlapping or touching spans, sum sizes
  function automatic logic [63:0] merged_span(output logic sat);
    logic [63:0] lo_s [MaxEntries];
    logic [63:0] hi_s [MaxEntries];
    logic [63:0] lo_k, hi_k, cur_lo, cur_hi, total;
    int j;
    sat = 1'b0;
    total = '0;
    if (shadow_count == 0) return '0;
    for (int i = 0; i < shadow_count; i++) begin
      lo_k = shadow_lo[i];
      hi_k = shadow_hi[i];
      j = i;
      while (j > 0 && lo_s[j-1] > lo_k) begin
        lo_s[j] = lo_s[j-1];
        hi_s[j] = hi_s[j-1];
        j--;
      end
      lo_s[j] = lo_k;
      hi_s[j] = hi_k;
    end
    cur_lo = lo_s[0];
    cur_hi = hi_s[0];
    for (int i = 1; i < shadow_count; i++) begin
      // lo above cur_hi here, so the difference cannot wrap
      if (lo_s[i] <= cur_hi || lo_s[i] - cur_hi == 64'd1) begin
        if (hi_s[i] > cur_hi) cur_hi = hi_s[i];
      end else begin
        total = sat_add(total, cur_hi - cur_lo, sat);
        total = sat_add(total, 64'd1, sat);
        cur_lo = lo_s[i];
        cur_hi = hi_s[i];
      end
    end
    total = sat_add(total, cur_hi - cur_lo, sat);
    total = sat_add(total, 64'd1, sat);
    return total;
  endfunction

  // apply one command to the shadow and return its result
  function automatic out_beat_t table_step(input in_beat_t cmd);
    out_beat_t res;
    logic sat;
    res = '0;
    res.status = StatusOk;
    case (cmd.command)
      CmdClear: begin
        shadow_count = 0;
        shadow_tally = '0;
      end
      CmdAdd: begin
        if (cmd.low_bound <= cmd.high_bound) begin
          if (shadow_count >= MaxEntries) begin
            res.status = StatusFull;
          end else begin
            shadow_lo[shadow_count] = cmd.low_bound;
            shadow_hi[shadow_count] = cmd.high_bound;
            shadow_count++;
          end
        end
      end
      CmdTest: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (cmd.probe_value >= shadow_lo[i] && cmd.probe_value <= shadow_hi[i])
            res.probe_hit = 1'b1;
        end
        if (res.probe_hit && shadow_tally != '1) shadow_tally++;
      end
      default: begin
        res.union_size = merged_span(sat);
        if (sat) res.status = StatusSat;
      end
    endcase
    res.hits_so_far = shadow_tally;
    res.stored_intervals = shadow_count[8:0];
    return res;
  endfunction

  // predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_b;
    if (!rst_ni) begin
      shadow_count = 0;
      shadow_tally = '0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_results = {expected_results, table_step(in_data_i)};
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = expected_results.pop_front();
          if (out_data_i !== exp_b) begin
            fail_count_o <= fail_count_o + 1;
            if (out_data_i.probe_hit !== exp_b.probe_hit)
              $error("probe_hit exp %0d got %0d", exp_b.probe_hit, out_data_i.probe_hit);
            if (out_data_i.hits_so_far !== exp_b.hits_so_far)
              $error("hits_so_far exp %0d got %0d", exp_b.hits_so_far,
                     out_data_i.hits_so_far);
            if (out_data_i.union_size !== exp_b.union_size)
              $error("union_size exp %0h got %0h", exp_b.union_size, out_data_i.union_size);
            if (out_data_i.stored_intervals !== exp_b.stored_intervals)
              $error("stored_intervals exp %0d got %0d", exp_b.stored_intervals,
                     out_data_i.stored_intervals);
            if (out_data_i.status !== exp_b.status)
              $error("status exp %0d got %0d", exp_b.status, out_data_i.status);
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

@@ tb/sv/interval_table_match_and_union_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_match_and_union_tb
// Directed corner commands, then random add/test/report runs on small tables,
// one full-table fill, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------

module interval_table_match_and_union_tb;
  import itmu_pkg::*;

  localparam int          RandItems  = 1130;
  localparam int          CycleLimit = 2_000_000;
  localparam logic [63:0] Top        = '1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  int        fail_count, pending;
  int        send_idle_pct = 24, recv_idle_pct = 55;
  int        hold_cycles = 0;
  int        cycle_count = 0;
  int        beat_count = 0;

  always #2 clk_i = ~clk_i;

  interval_table_match_and_union i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  interval_table_match_and_union_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one command beat; valid held until accepted, dropped only when idling
  task automatic send_cmd(input cmd_e cmd, input logic [63:0] lo, input logic [63:0] hi,
                          input logic [63:0] probe);
    in_beat_t b;
    b.command = cmd;
    b.low_bound = lo;
    b.high_bound = hi;
    b.probe_value = probe;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (!in_ready);
    beat_count++;
  endtask

  // drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || out_valid) @(posedge clk_i);
  endtask

  // value mix: full random, small, near the top, around a base
  function automatic logic [63:0] rand_value();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(400));
      2: return Top - 64'($urandom_range(400));
      default: return 64'h8000_0000_0000_0000 + 64'($urandom_range(400));
    endcase
  endfunction

  task automatic rand_add();
    logic [63:0] lo, hi;
    lo = rand_value();
    if ($urandom_range(9) == 0) hi = rand_value();
    else if ($urandom_range(9) == 0) hi = {$urandom, $urandom};
    else hi = lo + 64'($urandom_range(60));
    send_cmd(CmdAdd, lo, hi, {$urandom, $urandom});
  endtask

  initial begin
    int n;
    logic stall_done;
    logic fill_done;
    logic [63:0] fill_lo;
    stall_done = 1'b0;
    fill_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, reversed add, extremes, touching, whole range
    send_cmd(CmdReport, 0, 0, 0);
    send_cmd(CmdTest, 0, 0, 0);
    send_cmd(CmdAdd, 64'd9, 64'd3, 0);
    send_cmd(CmdAdd, 0, 0, 0);
    send_cmd(CmdAdd, Top, Top, 0);
    send_cmd(CmdTest, 0, 0, 0);
    send_cmd(CmdTest, 0, 0, Top);
    send_cmd(CmdTest, 0, 0, 64'd1);
    send_cmd(CmdReport, 0, 0, 0);
    send_cmd(CmdClear, 0, 0, 0);
    send_cmd(CmdAdd, 0, Top, 0);
    send_cmd(CmdReport, 0, 0, 0);
    send_cmd(CmdClear, 0, 0, 0);
    send_cmd(CmdAdd, 64'd10, 64'd20, 0);
    send_cmd(CmdAdd, 64'd21, 64'd30, 0);
    send_cmd(CmdAdd, 64'd32, 64'd40, 0);
    send_cmd(CmdAdd, 64'd25, 64'd35, 0);
    send_cmd(CmdReport, 0, 0, 0);
    send_cmd(CmdTest, 0, 0, 64'd31);
    send_cmd(CmdAdd, 64'h8000_0000_0000_0000, Top, 0);
    send_cmd(CmdAdd, 0, 64'h7fff_ffff_ffff_ffff, 0);
    send_cmd(CmdReport, 0, 0, 0);
    send_cmd(CmdClear, 0, 0, 0);

    // random runs: a clear or an occasional random command, a few adds, then tests and reports
    n = 0;
    while (n < RandItems) begin
      if (n > RandItems / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 24;
      end
      if (n > 2 * RandItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!stall_done && n >= 400) begin
        // long output stall while commands keep coming
        stall_done = 1'b1;
        hold_cycles = 700;
      end
      if (!fill_done && n >= 600) begin
        fill_done = 1'b1;
        wait_drained();
        // fill the table with well-formed spans, overflow it, probe and report once
        send_cmd(CmdClear, 0, 0, 0);
        for (int i = 0; i < 256; i++) begin
          fill_lo = rand_value();
          send_cmd(CmdAdd, fill_lo, fill_lo | 64'($urandom_range(63)), 0);
        end
        while (pending < 0) @(posedge clk_i);
        for (int i = 0; i < 3; i++) send_cmd(CmdAdd, 64'd5, 64'd7, 0);
        send_cmd(CmdTest, 0, 0, rand_value());
        send_cmd(CmdReport, 0, 0, 0);
        send_cmd(CmdClear, 0, 0, 0);
        n += 262;
      end
      if ($urandom_range(9) == 0) send_cmd(cmd_e'($urandom_range(3)), rand_value(),
                                           rand_value(), rand_value());
      else send_cmd(CmdClear, 0, 0, 0);
      n++;
      repeat ($urandom_range(12)) begin
        rand_add();
        n++;
      end
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(4) == 0) send_cmd(CmdReport, 0, 0, rand_value());
        else send_cmd(CmdTest, rand_value(), rand_value(), rand_value());
        n++;
      end
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d command beats: corners, small random tables, a full table,", beat_count);
    $display("both idling mixes and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
